// ===== rtl/tvpm_pkg.sv =====
// Shared types, constants and helpers for the text video memory block.
`timescale 1ns / 1ps
`default_nettype none

package tvpm_pkg;

    // Memory geometry: words per plane (a power of two) and plane count.
    localparam int PLANE_WORDS = 65536;
    localparam int PLANE_COUNT = 4;

    // Address field layout: bit 0 picks the byte lane, bits 18:17 the plane.
    localparam int ADDR_W  = 19;
    localparam int PLANE_W = 2;
    localparam int SEL_W   = 4;
    localparam int OFS_W   = $clog2(PLANE_WORDS);
    localparam int RAM_DEPTH = PLANE_COUNT * PLANE_WORDS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Planes that really exist, one bit each.
    localparam logic [SEL_W-1:0] PLANE_VALID = SEL_W'((1 << PLANE_COUNT) - 1);

    // APB register map.
    localparam int PADDR_W = 3;
    localparam logic REG_PLANE_SELECT = 1'b0;
    localparam logic REG_WRITE_MASK   = 1'b1;

    typedef enum logic [1:0] {
        OP_READ_BYTE  = 2'd0,
        OP_READ_WORD  = 2'd1,
        OP_WRITE_BYTE = 2'd2,
        OP_WRITE_WORD = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [18:0] address;
        logic [15:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [15:0] read_data;
        logic        wait_state;
        logic        content_changed;
    } t_out_word;

    // Pick the lowest plane still pending.
    function automatic logic [PLANE_W-1:0] f_first_plane(input logic [SEL_W-1:0] mask);
        logic [PLANE_W-1:0] plane;
        plane = '0;
        if (mask[0]) begin
            plane = 2'd0;
        end else if (mask[1]) begin
            plane = 2'd1;
        end else if (mask[2]) begin
            plane = 2'd2;
        end else if (mask[3]) begin
            plane = 2'd3;
        end
        return plane;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tvpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tvpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/text_vram_plane_mask_access.sv =====
// Top level of the four-plane text video memory with masked plane writes.
//
//  Channel   Direction  Handshake                   Word
//  in        input      i_in_valid / o_in_stall     t_in_word  (opcode, address, write_data)
//  out       output     o_out_valid / i_out_stall   t_out_word (read_data, wait_state,
//                                                              content_changed)
//  config    input      APB psel/penable/pwrite     plane_select @0x0, write_mask @0x4
//
// A read does one RAM read of its plane; a write does one RAM read and one
// merge-and-write per plane written, through the shared merge unit.
// After reset a clearing pass writes zero to all 262144 words, one per cycle;
// o_in_stall stays high during that pass, config writes are still taken.
// A finished word waits in the output register; the next input word is taken
// meanwhile and the block holds its result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module text_vram_plane_mask_access
    import tvpm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input word channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_word            i_in_word,
    // result word channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_word                o_out_word,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    t_state              r_state, n_state;
    logic [RAM_AW-1:0]   r_clr_addr;
    logic [SEL_W-1:0]    r_plane_select;
    logic [15:0]         r_write_mask;
    logic [1:0]          r_phase;

    // Item being worked on
    t_opcode             r_op;
    logic [OFS_W-1:0]    r_off;
    logic                r_high;
    logic [15:0]         r_wdata;
    logic [SEL_W-1:0]    r_pmask;
    logic [15:0]         r_rd;
    logic                r_chg;
    logic                r_wait;

    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                in_acc;
    logic                out_free;
    logic                is_write;
    logic                is_byte;
    logic [PLANE_W-1:0]  cur_plane;
    logic [SEL_W-1:0]    cur_bit;
    logic [SEL_W-1:0]    rest_mask;
    logic [PLANE_W-1:0]  acc_plane;
    logic [SEL_W-1:0]    acc_mask;
    logic                cfg_we;

    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [15:0]         ram_wdata;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [15:0]         ram_rdata;

    logic [15:0]         keep;
    logic [15:0]         wr_word;
    logic [15:0]         merged;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_write = (r_op == OP_WRITE_BYTE) || (r_op == OP_WRITE_WORD);
    assign is_byte  = (r_op == OP_READ_BYTE) || (r_op == OP_WRITE_BYTE);

    // Plane under work and the planes left after it
    assign cur_plane = f_first_plane(r_pmask);
    assign cur_bit   = SEL_W'(1) << cur_plane;
    assign rest_mask = r_pmask & ~cur_bit;

    // Planes touched by an incoming word: direct plane, or the nonzero select set on writes
    always_comb begin
        acc_plane = i_in_word.address[ADDR_W-1 -: PLANE_W];
        acc_mask  = '0;
        if (32'(acc_plane) < PLANE_COUNT) begin
            acc_mask = SEL_W'(1) << acc_plane;
        end
        if (((i_in_word.opcode == OP_WRITE_BYTE) || (i_in_word.opcode == OP_WRITE_WORD))
                && (r_plane_select != '0)) begin
            acc_mask = r_plane_select & PLANE_VALID;
        end
    end

    // Shared merge unit: keep masked bits of the stored word
    always_comb begin
        if (is_byte) begin
            if (r_high) begin
                keep    = {r_write_mask[15:8], 8'hff};
                wr_word = {r_wdata[7:0], 8'h00};
            end else begin
                keep    = {8'hff, r_write_mask[7:0]};
                wr_word = {8'h00, r_wdata[7:0]};
            end
        end else begin
            keep    = r_write_mask;
            wr_word = r_wdata;
        end
        merged = (ram_rdata & keep) | (wr_word & ~keep);
    end

    // Sequencer: next state and RAM control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = RAM_AW'({cur_plane, r_off});
        ram_wdata = merged;
        ram_raddr = RAM_AW'({cur_plane, r_off});
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (acc_mask == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (is_write) begin
                    ram_we  = 1'b1;
                    n_state = (rest_mask != '0) ? ST_READ : ST_DONE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
        end
    end

    // Configuration registers
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_select <= '0;
            r_write_mask   <= '0;
        end else if (cfg_we) begin
            if (paddr[2] == REG_PLANE_SELECT) begin
                r_plane_select <= pwdata[SEL_W-1:0];
            end
            if (paddr[2] == REG_WRITE_MASK) begin
                r_write_mask <= pwdata[15:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WRITE_MASK) ? {16'h0000, r_write_mask}
                                                 : {{(32 - SEL_W){1'b0}}, r_plane_select};

    // Step the access phase once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_acc) begin
            r_phase <= r_phase + 2'd1;
        end
    end

    // Capture the word and collect its result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_in_word.opcode;
            r_off   <= OFS_W'(i_in_word.address[16:1]);
            r_high  <= !i_in_word.address[0];
            r_wdata <= i_in_word.write_data;
            r_pmask <= acc_mask;
            r_rd    <= '0;
            r_chg   <= 1'b0;
            r_wait  <= (r_phase + 2'd1) != 2'd0;
        end else if (r_state == ST_MERGE) begin
            r_pmask <= rest_mask;
            if (is_write) begin
                r_chg <= r_chg || (merged != ram_rdata);
            end else if (is_byte) begin
                r_rd <= r_high ? {8'h00, ram_rdata[15:8]} : {8'h00, ram_rdata[7:0]};
            end else begin
                r_rd <= ram_rdata;
            end
        end
    end

    // Output register: load when the result is done and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_word.read_data       <= r_rd;
            r_out_word.wait_state      <= r_wait;
            r_out_word.content_changed <= r_chg;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    tvpm_ram #(
        .WIDTH (16),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // No RAM write while a plane read is in flight
    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !ram_we)
        else $error("RAM written during plane read");

    // A merge always works on a pending plane
    a_merge_has_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_pmask != '0))
        else $error("merge with no plane pending");

    // A result appears only out of the done step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result word loaded outside done step");

    // An accepted word leaves the idle state
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("still idle after accepting a word");

endmodule

`default_nettype wire
